@@ src/chroma_luma_ratio_newton_fit_top_defines.svh @@
// assertion macros for the chroma-from-luma fit block
`ifndef CHROMA_LUMA_RATIO_NEWTON_FIT_TOP_DEFINES_SVH
`define CHROMA_LUMA_RATIO_NEWTON_FIT_TOP_DEFINES_SVH

// same-cycle implication
`define CLRNF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clrnf same-cycle check failed");

// next-cycle implication
`define CLRNF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clrnf next-cycle check failed");

`endif

@@ src/clrnf_pkg.sv @@
// shared constants and controller/datapath types for the chroma-from-luma fit
`timescale 1ns / 1ps
`default_nettype none
package clrnf_pkg;
   localparam int MAX_PAIRS      = 4096;
   localparam int MAX_ITERATIONS = 20;
   localparam int IDX_W   = $clog2(MAX_PAIRS);
   localparam int CNT_W   = $clog2(MAX_PAIRS + 1);
   localparam int ITER_W  = $clog2(MAX_ITERATIONS + 1);
   localparam int X_W     = 32;
   localparam int SUM_W   = 64;
   localparam int DIV_W   = 72;
   localparam int Q_W     = 22;
   localparam int STEP_W  = Q_W - 1;
   localparam int DIV_STEPS = Q_W;
   localparam int DIVC_W  = $clog2(DIV_STEPS);
   localparam int ADDR_W  = 4;

   localparam logic [1:0] REG_INV_COLOR_FACTOR = 2'd0;
   localparam logic [1:0] REG_BASE_RATIO       = 2'd1;
   localparam logic [1:0] REG_DISTANCE_WEIGHT  = 2'd2;

   typedef struct packed {
      logic             write_pair;
      logic             fit_start;
      logic             pass_init;
      logic             seed;
      logic             issue;
      logic [IDX_W-1:0] idx;
      logic             den_calc;
      logic             check;
      logic             div_step;
      logic             update;
      logic             emit;
   } cmd_type;

   typedef struct packed {
      logic             busy;
      logic             den_zero;
      logic             quot_big;
      logic             stop;
      logic             rsp_free;
      logic [CNT_W-1:0] count;
   } status_type;
endpackage
`default_nettype wire

@@ src/clrnf_if.sv @@
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface clrnf_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] main_value;
   logic signed [31:0] side_value;
   logic               last_value;
   modport source (output valid, main_value, side_value, last_value, input ready);
   modport sink (input valid, main_value, side_value, last_value, output ready);
endinterface

interface clrnf_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] multiplier;
   logic              pairs_dropped;
   modport source (output valid, multiplier, pairs_dropped, input ready);
   modport sink (input valid, multiplier, pairs_dropped, output ready);
endinterface
`default_nettype wire

@@ src/clrnf_datapath.sv @@
// pair store, derivative pipeline, step divider and multiplier update
`timescale 1ns / 1ps
`default_nettype none
module clrnf_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire clrnf_pkg::cmd_type    cmd,
   output clrnf_pkg::status_type      status,
   input  wire logic signed [31:0]    main_value,
   input  wire logic signed [31:0]    side_value,
   input  wire logic [23:0]           inv_color_factor,
   input  wire logic signed [23:0]    base_ratio,
   input  wire logic [31:0]           distance_weight,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output logic signed [7:0]          multiplier,
   output logic                       pairs_dropped
);
   localparam int ONE_Q16   = 65536;
   localparam int THRES_Q16 = 100 * 65536;
   localparam int CLAMP_Q16 = 20 * 65536;
   localparam int STOP_Q16  = 197;
   localparam int THIRD_HI  = 5592405;
   localparam int THIRD_LO  = 44739243;

   function automatic logic [32:0] abs_one(input logic signed [33:0] w);
      logic [33:0] m;
      m = w[33] ? 34'(-w) : 34'(w);
      return 33'(m) + 33'(ONE_Q16);
   endfunction

   // pair store
   logic [63:0] store_mem [clrnf_pkg::MAX_PAIRS];
   logic [63:0] rd_ff;
   logic [clrnf_pkg::CNT_W-1:0] count_ff, count_in;
   logic ovf_ff, ovf_in;
   logic full;

   assign full = count_ff == clrnf_pkg::CNT_W'(clrnf_pkg::MAX_PAIRS);

   always_ff @(posedge clock) begin
      if (cmd.write_pair && !full) begin
         store_mem[count_ff[clrnf_pkg::IDX_W-1:0]] <= {main_value, side_value};
      end
      rd_ff <= store_mem[cmd.idx];
   end

   always_comb begin
      count_in = count_ff;
      ovf_in = ovf_ff;
      if (cmd.emit) begin
         count_in = '0;
         ovf_in = 1'b0;
      end else if (cmd.write_pair) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff <= ovf_in;
      end
   end

   // pipeline valids
   logic [8:1] vld_ff;
   logic       in_range;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[7:5], vld_ff[4] & in_range, vld_ff[3:1], cmd.issue};
      end
   end

   // stage 2: products for a and b
   logic signed [31:0] main_rd, side_rd;
   logic signed [24:0] inv_s;
   logic signed [56:0] prod_a_ff;
   logic signed [55:0] prod_b_ff;
   logic signed [31:0] side2_ff;

   assign main_rd = rd_ff[63:32];
   assign side_rd = rd_ff[31:0];
   assign inv_s = {1'b0, inv_color_factor};

   always_ff @(posedge clock) begin
      prod_a_ff <= main_rd * inv_s;
      prod_b_ff <= main_rd * base_ratio;
      side2_ff <= side_rd;
   end

   // stage 3: a and b
   logic signed [56:0] a_rnd;
   logic signed [55:0] b_rnd;
   logic signed [40:0] b_in;
   logic signed [32:0] a3_ff;
   logic signed [40:0] b3_ff;

   assign a_rnd = prod_a_ff + 57'sd8388608;
   assign b_rnd = prod_b_ff + 56'sd32768;
   assign b_in = $signed(b_rnd[55:16]) - side2_ff;

   always_ff @(posedge clock) begin
      a3_ff <= $signed(a_rnd[56:24]);
      b3_ff <= b_in;
   end

   // stage 4: a times x
   logic signed [X_W_M:0] unused_dummy;
   localparam int X_W_M = clrnf_pkg::X_W - 1;
   logic signed [clrnf_pkg::X_W-1:0] x_ff;
   logic signed [64:0] ax_ff;
   logic signed [32:0] a4_ff;
   logic signed [40:0] b4_ff;

   assign unused_dummy = x_ff;

   always_ff @(posedge clock) begin
      ax_ff <= a3_ff * unused_dummy;
      a4_ff <= a3_ff;
      b4_ff <= b3_ff;
   end

   // stage 5: residuals at x, x+1, x-1
   logic signed [64:0] ax_rnd;
   logic signed [49:0] v;
   logic signed [33:0] w [3];
   logic [32:0] u_ff [3];
   logic [2:0]  neg5_ff;
   logic [31:0] abs_a_ff;

   assign ax_rnd = ax_ff + 65'sd32768;
   assign v = $signed(ax_rnd[64:16]) + b4_ff;
   assign in_range = (v < 50'sd6553600) && (v > -50'sd6553600);
   assign w[0] = 34'($signed(v[23:0]));
   assign w[1] = 34'($signed(v[23:0])) + 34'(a4_ff);
   assign w[2] = 34'($signed(v[23:0])) - 34'(a4_ff);

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         u_ff[k] <= abs_one(w[k]);
         neg5_ff[k] <= w[k][33] ^ a4_ff[32];
      end
      abs_a_ff <= a4_ff[32] ? 32'(-a4_ff) : 32'(a4_ff);
   end

   // stage 6: magnitudes
   logic [64:0] mag_ff [3];
   logic [2:0]  neg6_ff;

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         mag_ff[k] <= u_ff[k] * abs_a_ff;
      end
      neg6_ff <= neg5_ff;
   end

   // stage 7: divide by three in two halves
   logic [64:0] yfull [3];
   logic [47:0] y [3];
   logic [24:0] z [3];
   logic [46:0] phi_ff [3];
   logic [50:0] plo_ff [3];
   logic [2:0]  neg7_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         yfull[k] = mag_ff[k] + 65'd49152;
         y[k] = yfull[k][62:15];
         z[k] = {1'b0, y[k][47:24]} + {1'b0, y[k][23:0]};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         phi_ff[k] <= y[k][47:24] * 23'(THIRD_HI);
         plo_ff[k] <= z[k] * 26'(THIRD_LO);
      end
      neg7_ff <= neg6_ff;
   end

   // stage 8: signed terms
   logic [47:0] t [3];
   logic signed [48:0] term_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         t[k] = 48'(phi_ff[k]) + 48'(plo_ff[k][50:27]);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         term_ff[k] <= neg7_ff[k] ? -$signed({1'b0, t[k]}) : $signed({1'b0, t[k]});
      end
   end

   // distance term and sums
   logic [45:0] dnp;
   logic [29:0] dn_ff;
   logic signed [31:0] dn2_s;
   logic signed [63:0] dprod_ff;
   logic signed [63:0] dprod_rnd;
   logic signed [47:0] s0;
   logic signed [clrnf_pkg::SUM_W-1:0] sum_ff [3];

   assign dnp = 46'(distance_weight) * 46'(count_ff) + 46'd32768;
   assign dn2_s = {1'b0, dn_ff, 1'b0};
   assign dprod_rnd = dprod_ff + 64'sd32768;
   assign s0 = $signed(dprod_rnd[63:16]);

   always_ff @(posedge clock) begin
      if (cmd.fit_start) begin
         dn_ff <= dnp[45:16];
      end
      if (cmd.pass_init) begin
         dprod_ff <= dn2_s * x_ff;
      end
      if (cmd.seed) begin
         sum_ff[0] <= clrnf_pkg::SUM_W'(s0);
         sum_ff[1] <= clrnf_pkg::SUM_W'(s0) + clrnf_pkg::SUM_W'(dn2_s);
         sum_ff[2] <= clrnf_pkg::SUM_W'(s0) - clrnf_pkg::SUM_W'(dn2_s);
      end else if (vld_ff[8]) begin
         for (int k = 0; k < 3; k++) begin
            sum_ff[k] <= sum_ff[k] + clrnf_pkg::SUM_W'(term_ff[k]);
         end
      end
   end

   // step division
   logic signed [64:0] den;
   logic [64:0] den_abs;
   logic [63:0] g0_abs;
   logic [clrnf_pkg::DIV_W-1:0] nm_ff, dm_ff, rem_ff, dm20, dsh;
   logic den_zero_ff, g0_zero_ff, neg_ff, big_ff;
   logic [clrnf_pkg::Q_W-1:0] q_ff;

   assign den = 65'(sum_ff[1]) - 65'(sum_ff[2]);
   assign den_abs = den[64] ? 65'(-den) : 65'(den);
   assign g0_abs = sum_ff[0][63] ? 64'(-sum_ff[0]) : 64'(sum_ff[0]);
   assign dsh = dm_ff << 4;
   assign dm20 = dsh + (dm_ff << 2);

   always_ff @(posedge clock) begin
      if (cmd.den_calc) begin
         nm_ff <= {clrnf_pkg::DIV_W'(g0_abs), 1'b0} [clrnf_pkg::DIV_W-1:0];
         dm_ff <= clrnf_pkg::DIV_W'(den_abs);
         den_zero_ff <= den == 65'sd0;
         g0_zero_ff <= sum_ff[0] == '0;
         neg_ff <= (den == 65'sd0) ? sum_ff[0][63] : (sum_ff[0][63] ^ den[64]);
      end
      if (cmd.check) begin
         big_ff <= nm_ff >= dm20;
         rem_ff <= nm_ff;
         q_ff <= '0;
      end else if (cmd.div_step) begin
         if (rem_ff >= dsh) begin
            rem_ff <= (rem_ff - dsh) << 1;
            q_ff <= {q_ff[clrnf_pkg::Q_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_ff << 1;
            q_ff <= {q_ff[clrnf_pkg::Q_W-2:0], 1'b0};
         end
      end
   end

   // step and update of x
   logic [clrnf_pkg::Q_W:0] qr;
   logic [clrnf_pkg::STEP_W-1:0] step_mag;
   logic signed [clrnf_pkg::X_W-1:0] step_x;

   assign qr = {1'b0, q_ff} + 1'b1;

   always_comb begin
      if (den_zero_ff) begin
         step_mag = g0_zero_ff ? '0 : clrnf_pkg::STEP_W'(CLAMP_Q16);
      end else if (big_ff) begin
         step_mag = clrnf_pkg::STEP_W'(CLAMP_Q16);
      end else begin
         step_mag = qr[clrnf_pkg::Q_W-1:1];
      end
   end

   assign step_x = clrnf_pkg::X_W'($signed({1'b0, step_mag}));

   // rounded, clamped result
   logic [clrnf_pkg::X_W-1:0] x_abs;
   logic [clrnf_pkg::X_W-1:0] x_rnd;
   logic [15:0] r;
   logic signed [7:0] res;

   assign x_abs = x_ff[clrnf_pkg::X_W-1] ? clrnf_pkg::X_W'(-x_ff) : clrnf_pkg::X_W'(x_ff);
   assign x_rnd = x_abs + clrnf_pkg::X_W'(32768);
   assign r = x_rnd[clrnf_pkg::X_W-1:16];

   always_comb begin
      if (x_ff[clrnf_pkg::X_W-1]) begin
         res = (r > 16'd128) ? -8'sd128 : $signed(8'(16'd0 - r));
      end else begin
         res = (r > 16'd127) ? 8'sd127 : $signed(r[7:0]);
      end
   end

   logic rsp_valid_ff;
   logic signed [7:0] mult_ff;
   logic dropped_ff;

   always_ff @(posedge clock) begin
      if (cmd.fit_start) begin
         x_ff <= '0;
      end else if (cmd.update) begin
         x_ff <= neg_ff ? x_ff + step_x : x_ff - step_x;
      end
      if (cmd.emit) begin
         mult_ff <= res;
         dropped_ff <= ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign multiplier = mult_ff;
   assign pairs_dropped = dropped_ff;

   assign status.busy = |vld_ff;
   assign status.den_zero = den_zero_ff;
   assign status.quot_big = nm_ff >= dm20;
   assign status.stop = step_mag < clrnf_pkg::STEP_W'(STOP_Q16);
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;
   assign status.count = count_ff;
endmodule
`default_nettype wire

@@ src/clrnf_ctrl.sv @@
// sequencer for loading, derivative passes, step division and result
`timescale 1ns / 1ps
`default_nettype none
module clrnf_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_last,
   output logic                       req_ready,
   input  wire clrnf_pkg::status_type status,
   output clrnf_pkg::cmd_type         cmd
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DN     = 4'd1;
   localparam logic [3:0] S_PASS   = 4'd2;
   localparam logic [3:0] S_SEED   = 4'd3;
   localparam logic [3:0] S_STREAM = 4'd4;
   localparam logic [3:0] S_DRAIN  = 4'd5;
   localparam logic [3:0] S_DEN    = 4'd6;
   localparam logic [3:0] S_CHK    = 4'd7;
   localparam logic [3:0] S_DIV    = 4'd8;
   localparam logic [3:0] S_UPD    = 4'd9;
   localparam logic [3:0] S_OUT    = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [clrnf_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [clrnf_pkg::ITER_W-1:0] iter_ff, iter_in;
   logic [clrnf_pkg::DIVC_W-1:0] divc_ff, divc_in;
   logic last_idx;

   assign last_idx = {1'b0, idx_ff} == (status.count - 1'b1);

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      iter_in = iter_ff;
      divc_in = divc_ff;
      req_ready = 1'b0;
      cmd = '0;
      cmd.idx = idx_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.write_pair = 1'b1;
               if (req_last) begin
                  state_in = S_DN;
               end
            end
         end
         S_DN: begin
            cmd.fit_start = 1'b1;
            iter_in = '0;
            state_in = S_PASS;
         end
         S_PASS: begin
            cmd.pass_init = 1'b1;
            state_in = S_SEED;
         end
         S_SEED: begin
            cmd.seed = 1'b1;
            idx_in = '0;
            state_in = S_STREAM;
         end
         S_STREAM: begin
            cmd.issue = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (last_idx) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!status.busy) begin
               state_in = S_DEN;
            end
         end
         S_DEN: begin
            cmd.den_calc = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            cmd.check = 1'b1;
            divc_in = '0;
            state_in = (status.den_zero || status.quot_big) ? S_UPD : S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            divc_in = divc_ff + 1'b1;
            if (divc_ff == clrnf_pkg::DIVC_W'(clrnf_pkg::DIV_STEPS - 1)) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            cmd.update = 1'b1;
            iter_in = iter_ff + 1'b1;
            if (status.stop ||
                iter_ff == clrnf_pkg::ITER_W'(clrnf_pkg::MAX_ITERATIONS - 1)) begin
               state_in = S_OUT;
            end else begin
               state_in = S_PASS;
            end
         end
         S_OUT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= '0;
         iter_ff <= '0;
         divc_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         iter_ff <= iter_in;
         divc_ff <= divc_in;
      end
   end
endmodule
`default_nettype wire

@@ src/chroma_luma_ratio_newton_fit_top.sv @@
// top level of the chroma-from-luma multiplier fit with its register port
// Each pair item is taken while idle and written to a 4096-entry pair store; an item
// marked last starts the fit. Every Newton pass streams the stored pairs through an
// eight-stage derivative pipeline at one pair per cycle, then a restoring divider forms
// the step, and a fit takes at most 20 passes before the result item is offered. The
// result sits in an output register; while it waits, pairs of the next set are already
// taken.
`timescale 1ns / 1ps
`default_nettype none
`include "chroma_luma_ratio_newton_fit_top_defines.svh"
module chroma_luma_ratio_newton_fit_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   clrnf_req_if.sink                          req_if,
   clrnf_rsp_if.source                        rsp_if,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [clrnf_pkg::ADDR_W-1:0]  csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   logic [23:0] inv_ff;
   logic signed [23:0] base_ff;
   logic [31:0] dist_ff;
   logic csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff <= 24'd199729;
         base_ff <= 24'sd65536;
         dist_ff <= 32'd4294967;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            clrnf_pkg::REG_INV_COLOR_FACTOR: inv_ff <= csr_pwdata[23:0];
            clrnf_pkg::REG_BASE_RATIO:       base_ff <= $signed(csr_pwdata[23:0]);
            clrnf_pkg::REG_DISTANCE_WEIGHT:  dist_ff <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         clrnf_pkg::REG_INV_COLOR_FACTOR: csr_prdata = {8'd0, inv_ff};
         clrnf_pkg::REG_BASE_RATIO:       csr_prdata = {8'd0, base_ff};
         clrnf_pkg::REG_DISTANCE_WEIGHT:  csr_prdata = dist_ff;
         default:                         csr_prdata = '0;
      endcase
   end

   clrnf_pkg::cmd_type    dp_cmd;
   clrnf_pkg::status_type dp_status;

   clrnf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_last  (req_if.last_value),
      .req_ready (req_if.ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   clrnf_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (dp_cmd),
      .status           (dp_status),
      .main_value       (req_if.main_value),
      .side_value       (req_if.side_value),
      .inv_color_factor (inv_ff),
      .base_ratio       (base_ff),
      .distance_weight  (dist_ff),
      .rsp_ready        (rsp_if.ready),
      .rsp_valid        (rsp_if.valid),
      .multiplier       (rsp_if.multiplier),
      .pairs_dropped    (rsp_if.pairs_dropped)
   );

   // pairs are only taken with the derivative pipeline empty
   `CLRNF_ASSERT_SAME(a_ready_idle_pipe, clock, reset, req_if.ready, !dp_status.busy)
   // a last item ends intake until the fit is done
   `CLRNF_ASSERT_NEXT(a_last_blocks, clock, reset,
      req_if.valid && req_if.ready && req_if.last_value, !req_if.ready)
   // a new result only follows a fit
   `CLRNF_ASSERT_SAME(a_rsp_after_fit, clock, reset, $rose(rsp_if.valid), $past(!req_if.ready))
endmodule
`default_nettype wire

@@ dv/tb_chroma_luma_ratio_newton_fit_top.sv @@
// self-checking testbench for the chroma-from-luma multiplier fit top level
`timescale 1ns / 1ps
`default_nettype none
module tb_chroma_luma_ratio_newton_fit_top;
   import clrnf_pkg::*;

   localparam int STORE_DEPTH = 4096;
   localparam int PASSES      = 20;
   localparam longint Q16_ONE = 65536;
   localparam longint THRES   = 100 * 65536;
   localparam longint CLAMP   = 20 * 65536;
   localparam longint STOP_LIM = 197;
   localparam longint SUM_SAT = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam int WATCHDOG    = 400000;
   localparam logic [ADDR_W-1:0] ADDR_INV  = ADDR_W'(4 * REG_INV_COLOR_FACTOR);
   localparam logic [ADDR_W-1:0] ADDR_BASE = ADDR_W'(4 * REG_BASE_RATIO);
   localparam logic [ADDR_W-1:0] ADDR_DIST = ADDR_W'(4 * REG_DISTANCE_WEIGHT);
   localparam logic [ADDR_W-1:0] ADDR_NONE = ADDR_W'(12);

   typedef struct {
      logic signed [7:0] mult;
      logic              drop;
   } fit_result_t;

   typedef struct {
      logic signed [31:0] main_v;
      logic signed [31:0] side_v;
      logic               last_v;
      bit                 typed;
      logic signed [7:0]  mult;
      logic               drop;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   clrnf_req_if req_if();
   clrnf_rsp_if rsp_if();

   chroma_luma_ratio_newton_fit_top uut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #6 clock = ~clock;

   // predictor state
   logic signed [31:0] luma_mem [STORE_DEPTH];
   logic signed [31:0] chroma_mem [STORE_DEPTH];
   int unsigned pairs_held = 0;
   bit dropped_seen = 0;
   logic [23:0] inv_factor = 24'd199729;
   logic [23:0] base_q16 = 24'd65536;
   logic [31:0] dist_q32 = 32'd4294967;

   fit_result_t fits_due [$];
   bit typed_now = 0;
   logic signed [7:0] typed_mult = '0;
   logic typed_drop = 1'b0;
   bit quiet = 0;
   int unsigned req_taken = 0;
   int unsigned mismatches = 0;
   int unsigned stall_cycles = 0;

   function automatic longint unsigned mag(longint v);
      return v < 0 ? 64'd0 - longint'(v) : longint'(v);
   endfunction

   function automatic longint rnd_shift(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint sat_sum(longint s, longint t);
      longint r;
      r = s + t;
      if (r > SUM_SAT) r = SUM_SAT;
      if (r < -SUM_SAT) r = -SUM_SAT;
      return r;
   endfunction

   function automatic longint slope_term(longint v, longint a);
      longint unsigned m;
      longint t;
      m = (mag(v) + Q16_ONE) * mag(a);
      t = longint'((m + 64'd49152) / 64'd98304);
      return ((v < 0) != (a < 0)) ? -t : t;
   endfunction

   function automatic longint luma_scaled(longint m);
      return rnd_shift(m * longint'(inv_factor), 24);
   endfunction

   function automatic longint luma_offset(longint m);
      return rnd_shift(longint'($signed(base_q16)) * m, 16);
   endfunction

   function automatic longint step_size(longint g0, longint den);
      longint unsigned nm, dm, ip, r, q;
      bit neg;
      if (den == 0) begin
         if (g0 == 0) return 0;
         return g0 > 0 ? CLAMP : -CLAMP;
      end
      neg = (g0 < 0) != (den < 0);
      nm = 2 * mag(g0);
      dm = mag(den);
      ip = nm / dm;
      if (ip >= 20) return neg ? -CLAMP : CLAMP;
      r = nm % dm;
      q = ip;
      for (int k = 0; k < 17; k++) begin
         r = r << 1;
         q = q << 1;
         if (r >= dm) begin
            r = r - dm;
            q = q | 1;
         end
      end
      q = (q + 1) >> 1;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic signed [7:0] fit_multiplier();
      longint x, r, dn, s0, sp, sm, a, b, v, st, ap;
      x = 0;
      for (int it = 0; it < PASSES; it++) begin
         dn = longint'((longint'(dist_q32) * longint'(pairs_held) + 64'd32768) >> 16);
         s0 = rnd_shift(2 * dn * x, 16);
         sp = rnd_shift(2 * dn * (x + Q16_ONE), 16);
         sm = rnd_shift(2 * dn * (x - Q16_ONE), 16);
         for (int i = 0; i < pairs_held; i++) begin
            a = luma_scaled(longint'(luma_mem[i]));
            b = luma_offset(longint'(luma_mem[i])) - longint'(chroma_mem[i]);
            v = rnd_shift(a * x, 16) + b;
            if (longint'(mag(v)) < THRES) begin
               s0 = sat_sum(s0, slope_term(v, a));
               sp = sat_sum(sp, slope_term(v + a, a));
               sm = sat_sum(sm, slope_term(v - a, a));
            end
         end
         st = step_size(s0, sp - sm);
         ap = st;
         if (ap > CLAMP) ap = CLAMP;
         if (ap < -CLAMP) ap = -CLAMP;
         x = x - ap;
         if (longint'(mag(st)) < STOP_LIM) break;
      end
      r = longint'((mag(x) + 64'd32768) >> 16);
      if (x < 0) r = -r;
      if (r > 127) r = 127;
      if (r < -128) r = -128;
      return 8'(r);
   endfunction

   // accept side: predictor update, result check, watchdog
   always @(posedge clock) begin
      fit_result_t got, due;
      bit moved;
      moved = 0;
      if (!reset && req_if.valid && req_if.ready) begin
         moved = 1;
         req_taken <= req_taken + 1;
         if (pairs_held < STORE_DEPTH) begin
            luma_mem[pairs_held] = req_if.main_value;
            chroma_mem[pairs_held] = req_if.side_value;
            pairs_held++;
         end else begin
            dropped_seen = 1;
         end
         if (req_if.last_value) begin
            due.mult = fit_multiplier();
            due.drop = dropped_seen;
            if (typed_now) begin
               due.mult = typed_mult;
               due.drop = typed_drop;
            end
            fits_due.push_back(due);
            pairs_held = 0;
            dropped_seen = 0;
         end
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         moved = 1;
         got.mult = rsp_if.multiplier;
         got.drop = rsp_if.pairs_dropped;
         if (fits_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result item: multiplier %0d dropped %0b",
                        got.mult, got.drop);
         end else begin
            due = fits_due.pop_front();
            if (got.mult !== due.mult || got.drop !== due.drop) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected %0d/%0b, got %0d/%0b",
                           due.mult, due.drop, got.mult, got.drop);
            end
         end
      end
      if (moved || reset) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG) begin
         $display("chroma_luma_ratio_newton_fit_top test failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   always @(negedge clock) begin
      rsp_if.ready <= quiet || ($urandom_range(99) >= 22);
   end

   task automatic send_pair(logic signed [31:0] m, logic signed [31:0] s, logic l,
                            bit typed, logic signed [7:0] em, logic ed);
      int unsigned seen;
      if (!quiet && $urandom_range(99) < 22) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.main_value = m;
      req_if.side_value = s;
      req_if.last_value = l;
      typed_now = typed;
      typed_mult = em;
      typed_drop = ed;
      seen = req_taken;
      do @(negedge clock); while (req_taken == seen);
      req_if.valid = 1'b0;
   endtask

   task automatic csr_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = addr;
      csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      case (addr)
         ADDR_INV: inv_factor = data[23:0];
         ADDR_BASE: base_q16 = data[23:0];
         ADDR_DIST: dist_q32 = data;
         default: ;
      endcase
   endtask

   task automatic drain();
      while (fits_due.size() != 0) @(negedge clock);
      repeat (64) @(negedge clock);
   endtask

   // mostly pairs whose residual lands near a chosen multiplier, some raw noise
   task automatic send_set(int n);
      longint m, a, b, x0, e;
      logic signed [31:0] mv, sv;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 20) begin
            mv = $urandom;
            sv = $urandom;
         end else begin
            m = longint'($urandom_range(0, ($urandom_range(1) != 0) ? 32'h00FF_FFFF : 32'h3FFF));
            if ($urandom_range(1) != 0) m = -m;
            a = luma_scaled(m);
            x0 = longint'($urandom_range(0, 80)) - 40;
            e = longint'($urandom_range(0, 200 * 65536)) - 100 * 65536;
            b = -a * x0 + e;
            mv = 32'(m);
            sv = 32'(luma_offset(m) - b);
         end
         send_pair(mv, sv, (i == n - 1), 0, '0, 1'b0);
      end
   endtask

   task automatic random_phase(int items);
      int sent, n;
      sent = 0;
      while (sent < items) begin
         n = ($urandom_range(99) < 90) ? $urandom_range(1, 12) : $urandom_range(13, 60);
         quiet = (sent > items / 3) && (sent < items / 2);
         send_set(n);
         sent += n;
      end
      quiet = 0;
      drain();
   endtask

   stim_row_t rows [] = '{
      '{32'sd0, 32'sd0, 1'b1, 1, 8'sd0, 1'b0},
      '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1, 8'sd0, 1'b0},
      '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1, 8'sd0, 1'b0},
      '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 0, 8'sd0, 1'b0},
      '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 0, 8'sd0, 1'b0},
      '{32'sd0, 32'sd0, 1'b1, 1, 8'sd0, 1'b0},
      '{32'h0001_0000, 32'h0000_8000, 1'b0, 0, 8'sd0, 1'b0},
      '{32'h0010_0000, 32'h0008_0000, 1'b0, 0, 8'sd0, 1'b0},
      '{32'hFFF0_0000, 32'hFFF4_0000, 1'b1, 0, 8'sd0, 1'b0},
      '{32'h8000_0000, 32'h8000_0000, 1'b1, 0, 8'sd0, 1'b0},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 0, 8'sd0, 1'b0},
      '{32'h0640_0000, 32'h0600_0000, 1'b0, 0, 8'sd0, 1'b0},
      '{32'hF9C0_0000, 32'hFA40_0000, 1'b1, 0, 8'sd0, 1'b0},
      '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 0, 8'sd0, 1'b0},
      '{32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 0, 8'sd0, 1'b0}
   };

   initial begin
      req_if.valid = 1'b0;
      req_if.main_value = '0;
      req_if.side_value = '0;
      req_if.last_value = 1'b0;
      rsp_if.ready = 1'b0;
      repeat (7) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      foreach (rows[i])
         send_pair(rows[i].main_v, rows[i].side_v, rows[i].last_v, rows[i].typed,
                   rows[i].mult, rows[i].drop);
      drain();

      // store overflow: pairs past the store are dropped and flagged
      for (int i = 0; i < STORE_DEPTH + 3; i++)
         send_pair(32'($urandom_range(0, 32'h000F_FFFF)), $urandom,
                   (i == STORE_DEPTH + 2), 0, '0, 1'b0);
      drain();

      random_phase(220);
      csr_write(ADDR_INV, 32'h00FF_FFFF);
      csr_write(ADDR_BASE, 32'h007F_FFFF);
      csr_write(ADDR_DIST, 32'hFFFF_FFFF);
      random_phase(200);
      csr_write(ADDR_INV, 32'h0000_0000);
      csr_write(ADDR_BASE, 32'h0080_0000);
      csr_write(ADDR_DIST, 32'h0000_0000);
      random_phase(200);
      csr_write(ADDR_NONE, $urandom);
      csr_write(ADDR_INV, 32'h0004_0000);
      csr_write(ADDR_BASE, 32'h0000_8000);
      csr_write(ADDR_DIST, 32'h0000_0000);
      random_phase(200);
      csr_write(ADDR_INV, $urandom);
      csr_write(ADDR_BASE, $urandom);
      csr_write(ADDR_DIST, $urandom_range(0, 32'h00FF_FFFF));
      random_phase(200);
      csr_write(ADDR_INV, 32'd199729);
      csr_write(ADDR_BASE, 32'h00FF_0000);
      csr_write(ADDR_DIST, 32'd4294967);
      random_phase(230);

      repeat (200) @(negedge clock);
      if (mismatches == 0 && fits_due.size() == 0) begin
         $display("chroma_luma_ratio_newton_fit_top test passed");
      end else begin
         $display("chroma_luma_ratio_newton_fit_top test failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
